FILE: rtl/psu_pkg.sv
// psu_pkg: shared types, constants and helper functions for the png scanline unfilter
// no dependencies

package psu_pkg;

  // default depth of the prior row store, in bytes
  localparam int unsigned MaxRowBytesDef = 32768;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 14;
  localparam int unsigned DimW = 14;
  localparam int unsigned RowIdxW = 13;
  localparam int unsigned LenW = 17;
  localparam logic [DimW-1:0] MaxDim = DimW'(8192);

  typedef enum logic [CfgIdxW-1:0] {
    REG_COLOR_TYPE = 2'd0,
    REG_IMAGE_WIDTH = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    FILT_NONE = 3'd0,
    FILT_SUB = 3'd1,
    FILT_UP = 3'd2,
    FILT_AVG = 3'd3,
    FILT_PAETH = 3'd4
  } filter_e;

  typedef enum logic [2:0] {
    CT_GREY = 3'd0,
    CT_RGB = 3'd2,
    CT_PALETTE = 3'd3,
    CT_GREY_ALPHA = 3'd4,
    CT_RGBA = 3'd6
  } color_type_e;

  // bytes per pixel minus one; unknown colour types behave as rgba
  function automatic logic [1:0] bpp_m1(input logic [2:0] ct);
    logic [1:0] r;
    case (ct)
      CT_GREY, CT_PALETTE: r = 2'd0;
      CT_GREY_ALPHA: r = 2'd1;
      CT_RGB: r = 2'd2;
      default: r = 2'd3;
    endcase
    return r;
  endfunction

  // paeth predictor on left, up and up-left bytes
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [9:0] da, db, dc;
    logic [9:0] pa, pb, pc;
    logic [7:0] r;
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
    pa = da[9] ? 10'(-da) : 10'(da);
    pb = db[9] ? 10'(-db) : 10'(db);
    pc = dc[9] ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) r = a;
    else if (pb <= pc) r = b;
    else r = c;
    return r;
  endfunction

endpackage

FILE: rtl/png_scanline_unfilter.sv
// png_scanline_unfilter: undoes png row filters on an inflated byte stream
// depends on psu_pkg
// path: an accepted byte is held in stage one, then its result in the result register
// throughput: one byte per cycle unless the output stalls, set by the single read
//   and single write port of the row store (read on accept, written with its result)
// reset: control state, counters and pixel history clear at once; the prior row store is
//   not cleared, each entry is written in a row before the next row reads it

module png_scanline_unfilter
  import psu_pkg::*;
#(
  parameter int unsigned MAX_ROW_BYTES = MaxRowBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // incoming stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
  input  logic                s_axis_tuser,   // [0] start_req
  // outgoing stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [7:0] pixel_byte
  output logic                m_axis_tlast,   // row_end
  output logic [1:0]          m_axis_tuser    // [0] image_end, [1] bad_filter
);

  localparam int unsigned AddrW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

  // configuration registers
  logic [2:0]      color_type_q;
  logic [DimW-1:0] image_width_q, image_height_q;

  // stream position state, updated as each request is accepted
  logic [AddrW-1:0]   pos_q, pos_d;
  logic [RowIdxW-1:0] row_q, row_d;
  filter_e            filt_q, filt_d;
  logic               expect_q, expect_d;
  logic               halted_q, halted_d;
  logic               pend_clr_q, pend_clr_d;

  // stage one: accepted byte plus its prior row byte
  logic             s1_valid_q, s1_valid_d;
  logic             s1_err_q, s1_err_d;
  logic [7:0]       s1_byte_q;
  filter_e          s1_filt_q;
  logic [AddrW-1:0] s1_pos_q;
  logic             s1_row0_q, s1_clr_q, s1_row_end_q, s1_img_end_q;
  logic [1:0]       s1_bpp_q;
  logic [7:0]       up_rdata_q;

  // pixel history and result register
  logic [31:0] left_q, upleft_q;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_pixel_q;
  logic        out_row_end_q, out_img_end_q, out_bad_q;

  // prior row store
  logic [7:0] prior_row_mem [MAX_ROW_BYTES];

  // handshake
  logic in_acc, s1_adv;
  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // derived geometry
  logic [1:0]      bpp_m1_w;
  logic [DimW-1:0] width_eff, height_eff;
  logic [LenW-1:0] row_len_raw, row_len;
  assign bpp_m1_w    = bpp_m1(color_type_q);
  assign width_eff   = (image_width_q == '0) ? DimW'(1) : image_width_q;
  assign height_eff  = (image_height_q == '0) ? DimW'(1) :
                       (image_height_q > MaxDim) ? MaxDim : image_height_q;
  assign row_len_raw = LenW'(width_eff) * LenW'({1'b0, bpp_m1_w} + 3'd1);
  assign row_len     = (row_len_raw > LenW'(MAX_ROW_BYTES)) ? LenW'(MAX_ROW_BYTES) : row_len_raw;

  // stage one control, start_req restarts position, row and error
  logic               start_w, halted_eff, expect_eff, pend_eff;
  logic [AddrW-1:0]   pos_eff;
  logic [RowIdxW-1:0] row_eff;
  logic               row_end_w, last_row_w;
  logic               data_acc, err_acc;

  assign start_w    = s_axis_tuser;
  assign halted_eff = start_w ? 1'b0 : halted_q;
  assign expect_eff = start_w ? 1'b1 : expect_q;
  assign pend_eff   = start_w ? 1'b1 : pend_clr_q;
  assign pos_eff    = start_w ? '0 : pos_q;
  assign row_eff    = start_w ? '0 : row_q;
  assign row_end_w  = (LenW'(pos_eff) + LenW'(1)) >= row_len;
  assign last_row_w = (DimW'(row_eff) + DimW'(1)) >= height_eff;
  assign err_acc    = in_acc && !halted_eff && expect_eff && (s_axis_tdata > 8'd4);
  assign data_acc   = in_acc && !halted_eff && !expect_eff;

  always_comb begin
    pos_d      = pos_q;
    row_d      = row_q;
    filt_d     = filt_q;
    expect_d   = expect_q;
    halted_d   = halted_q;
    pend_clr_d = pend_clr_q;
    if (in_acc) begin
      pos_d      = pos_eff;
      row_d      = row_eff;
      expect_d   = expect_eff;
      halted_d   = halted_eff;
      pend_clr_d = pend_eff;
      if (!halted_eff) begin
        if (expect_eff) begin
          if (err_acc) begin
            halted_d = 1'b1;
          end else begin
            filt_d   = filter_e'(s_axis_tdata[2:0]);
            expect_d = 1'b0;
          end
        end else begin
          pend_clr_d = 1'b0;
          if (row_end_w) begin
            pos_d      = '0;
            expect_d   = 1'b1;
            pend_clr_d = 1'b1;
            if (last_row_w) halted_d = 1'b1;
            else row_d = row_eff + RowIdxW'(1);
          end else begin
            pos_d = pos_eff + AddrW'(1);
          end
        end
      end
    end
  end

  // stage one occupancy and result register occupancy
  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_err_d   = s1_err_q;
    if (in_acc) begin
      s1_valid_d = data_acc || err_acc;
      s1_err_d   = err_acc;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  // stage two: reconstruction from left, up and up-left bytes
  logic [31:0] left_src, upleft_src;
  logic [7:0]  a_w, b_w, c_w, pred_w, recon_w;
  logic [8:0]  avg_sum;
  assign left_src   = s1_clr_q ? '0 : left_q;
  assign upleft_src = s1_clr_q ? '0 : upleft_q;
  assign a_w        = left_src[s1_bpp_q*8 +: 8];
  assign c_w        = upleft_src[s1_bpp_q*8 +: 8];
  assign b_w        = s1_row0_q ? 8'd0 : up_rdata_q;
  assign avg_sum    = {1'b0, a_w} + {1'b0, b_w};

  always_comb begin
    case (s1_filt_q)
      FILT_SUB:   pred_w = a_w;
      FILT_UP:    pred_w = b_w;
      FILT_AVG:   pred_w = avg_sum[8:1];
      FILT_PAETH: pred_w = paeth(a_w, b_w, c_w);
      default:    pred_w = 8'd0;
    endcase
  end

  function automatic logic [7:0] s_pixel_sum(input logic [7:0] x, input logic [7:0] p);
    return x + p;
  endfunction

  assign recon_w = s_pixel_sum(s1_byte_q, pred_w);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_type_q   <= CT_RGBA;
      image_width_q  <= DimW'(1);
      image_height_q <= DimW'(1);
      pos_q          <= '0;
      row_q          <= '0;
      filt_q         <= FILT_NONE;
      expect_q       <= 1'b1;
      halted_q       <= 1'b0;
      pend_clr_q     <= 1'b1;
      s1_valid_q     <= 1'b0;
      s1_err_q       <= 1'b0;
      out_valid_q    <= 1'b0;
      left_q         <= '0;
      upleft_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_COLOR_TYPE:   color_type_q <= cfg_wdata_i[2:0];
          REG_IMAGE_WIDTH:  image_width_q <= cfg_wdata_i;
          REG_IMAGE_HEIGHT: image_height_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      pos_q       <= pos_d;
      row_q       <= row_d;
      filt_q      <= filt_d;
      expect_q    <= expect_d;
      halted_q    <= halted_d;
      pend_clr_q  <= pend_clr_d;
      s1_valid_q  <= s1_valid_d;
      s1_err_q    <= s1_err_d;
      out_valid_q <= out_valid_d;
      // history shifts in the newest byte at the bottom
      if (s1_adv && !s1_err_q) begin
        left_q   <= {left_src[23:0], recon_w};
        upleft_q <= {upleft_src[23:0], b_w};
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q    <= s_axis_tdata;
      s1_filt_q    <= filt_q;
      s1_pos_q     <= pos_eff;
      s1_row0_q    <= (row_eff == '0);
      s1_clr_q     <= pend_eff;
      s1_bpp_q     <= bpp_m1_w;
      s1_row_end_q <= row_end_w;
      s1_img_end_q <= row_end_w && last_row_w;
    end
    if (s1_adv) begin
      out_pixel_q   <= s1_err_q ? 8'd0 : recon_w;
      out_row_end_q <= !s1_err_q && s1_row_end_q;
      out_img_end_q <= !s1_err_q && s1_img_end_q;
      out_bad_q     <= s1_err_q;
    end
  end

  // prior row store: read as a data byte is accepted, write as the result is registered
  always_ff @(posedge clk_i) begin
    if (s1_adv && !s1_err_q) prior_row_mem[s1_pos_q] <= recon_w;
    if (data_acc) up_rdata_q <= prior_row_mem[pos_eff];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pixel_q;
  assign m_axis_tlast  = out_row_end_q;
  assign m_axis_tuser  = {out_bad_q, out_img_end_q};

  // an error result carries nothing else
  a_bad_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_bad_q |-> out_pixel_q == 8'd0 && !out_row_end_q && !out_img_end_q)
    else $error("error result carries data or flags");

  // image end always closes a row
  a_img_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_img_end_q |-> out_row_end_q)
    else $error("image end without row end");

  // an error or image end still in stage one leaves the stream halted
  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && (s1_err_q || s1_img_end_q) |-> halted_q)
    else $error("stream not halted behind error or image end");

  // a stalled result register keeps the next byte from overtaking
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready && s1_valid_q |-> !s_axis_tready)
    else $error("input taken while both stages are full");

endmodule
